/* src/aabb_contact_pair_tracker_unit_assert.svh */
// Assertion macros shared by the contact pair tracker RTL.
`ifndef AABB_CONTACT_PAIR_TRACKER_UNIT_ASSERT_SVH
`define AABB_CONTACT_PAIR_TRACKER_UNIT_ASSERT_SVH

// Check cons in the same cycle whenever ante holds.
`define AABBCT_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check cons in the cycle after ante holds.
`define AABBCT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* src/aabbct_pkg.sv */
// Types, sizes and codes for the contact pair tracker.
package aabbct_pkg;

   localparam int PAIR_SLOTS = 32;
   localparam int ID_BITS    = 10;
   localparam int COORD_BITS = 24;
   localparam int SLOT_BITS  = $clog2(PAIR_SLOTS);
   localparam int CNT_BITS   = $clog2(PAIR_SLOTS + 1);
   localparam int FUNC_BITS  = 2;
   localparam int EVENT_BITS = 3;

   localparam logic [FUNC_BITS-1:0] FUNC_TEST   = 2'd0;
   localparam logic [FUNC_BITS-1:0] FUNC_FRAME  = 2'd1;
   localparam logic [FUNC_BITS-1:0] FUNC_REMOVE = 2'd2;

   localparam logic [EVENT_BITS-1:0] EV_NONE    = 3'd0;
   localparam logic [EVENT_BITS-1:0] EV_ENTER   = 3'd1;
   localparam logic [EVENT_BITS-1:0] EV_STAY    = 3'd2;
   localparam logic [EVENT_BITS-1:0] EV_EXIT    = 3'd3;
   localparam logic [EVENT_BITS-1:0] EV_DROPPED = 3'd4;

   typedef struct packed {
      logic [FUNC_BITS-1:0]         func;
      logic [ID_BITS-1:0]           id_a;
      logic [ID_BITS-1:0]           id_b;
      logic signed [COORD_BITS-1:0] center_a_x;
      logic signed [COORD_BITS-1:0] center_a_y;
      logic signed [COORD_BITS-1:0] center_a_z;
      logic signed [COORD_BITS-1:0] center_b_x;
      logic signed [COORD_BITS-1:0] center_b_y;
      logic signed [COORD_BITS-1:0] center_b_z;
      logic [COORD_BITS-1:0]        reach_x;
      logic [COORD_BITS-1:0]        reach_y;
      logic [COORD_BITS-1:0]        reach_z;
   } req_type;

   typedef struct packed {
      logic [EVENT_BITS-1:0] event_res;
      logic [ID_BITS-1:0]    first_id;
      logic [ID_BITS-1:0]    second_id;
      logic                  last_of_run;
   } rsp_type;

endpackage

/* src/aabbct_axis_unit.sv */
// Shared per-axis overlap unit: registered centre difference, then reach compare.
module aabbct_axis_unit
   import aabbct_pkg::*;
(
   input  logic                         clock,
   input  logic                         load,
   input  logic signed [COORD_BITS-1:0] center_a,
   input  logic signed [COORD_BITS-1:0] center_b,
   input  logic [COORD_BITS-1:0]        reach,
   output logic                         hit
);

   logic signed [COORD_BITS:0]   diff_ff;
   logic signed [COORD_BITS:0]   diff_in;
   logic signed [COORD_BITS+1:0] diff_ext;
   logic signed [COORD_BITS+1:0] reach_ext;
   logic signed [COORD_BITS+1:0] margin;

   assign diff_in = {center_a[COORD_BITS-1], center_a} - {center_b[COORD_BITS-1], center_b};

   always_ff @(posedge clock) begin
      if (load) begin
         diff_ff <= diff_in;
      end
   end

   // |d| < reach  <=>  reach - |d| > 0; fold the sign into add or subtract
   assign diff_ext  = {diff_ff[COORD_BITS], diff_ff};
   assign reach_ext = signed'({2'b00, reach});
   assign margin    = diff_ff[COORD_BITS] ? (reach_ext + diff_ext) : (reach_ext - diff_ext);
   assign hit       = !margin[COORD_BITS+1] && (margin != '0);

endmodule

/* src/aabb_contact_pair_tracker_unit.sv */
// Top level of the contact pair tracker: sequencer, pair table and result port.
//
// Usage: drive req_item and raise start; the item is taken at the rising edge where
// start is high and busy is low. busy then stays high until the last result of the item
// is presented: that result sits on rsp_item in the first cycle with busy low, so a new
// item can be taken at the edge that ends it.
// Each result appears on rsp_item for exactly one cycle with rsp_valid high; the
// receiver cannot stall it, so it must sample every strobe. last_of_run marks the
// final result of an item; every item gives at least one result.
// A test item with two distinct ids runs the three axes through one shared subtract/compare
// unit; for each axis it registers the centre difference, then compares it with the reach. It
// then searches the pair table, at most 32 stored pairs, one entry per cycle; the item
// ends early when an axis misses or the pair is found. End-of-frame and remove items sweep
// the table one entry per cycle, compacting kept pairs in place; each exit is held
// until the next one is found or the sweep ends. The table walk, one entry a cycle, sets the rate.
// Reset (synchronous, active high) empties the table and clears all seen marks at
// once; no clearing pass is needed.
module aabb_contact_pair_tracker_unit
   import aabbct_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_valid,
   output rsp_type rsp_item
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIFF,
      ST_CMP,
      ST_SEARCH,
      ST_SWEEP,
      ST_FINISH
   } state_type;

   localparam logic [1:0] AXIS_LAST = 2'd2;

   state_type state_ff, state_in;
   req_type   req_ff, req_in;
   logic [1:0]          axis_ff, axis_in;
   logic [CNT_BITS-1:0] idx_ff, idx_in;
   logic [CNT_BITS-1:0] wr_ff, wr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic [PAIR_SLOTS-1:0] seen_ff, seen_in;
   logic    pend_valid_ff, pend_valid_in;
   rsp_type pend_ff, pend_in;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_item_ff, rsp_item_in;

   logic [ID_BITS-1:0] pair_first_ff  [PAIR_SLOTS];
   logic [ID_BITS-1:0] pair_second_ff [PAIR_SLOTS];

   logic                 tab_we;
   logic [SLOT_BITS-1:0] tab_waddr;
   logic [ID_BITS-1:0]   tab_wfirst;
   logic [ID_BITS-1:0]   tab_wsecond;

   logic [SLOT_BITS-1:0] cur_idx;
   logic [ID_BITS-1:0]   ent_first;
   logic [ID_BITS-1:0]   ent_second;
   logic                 ent_seen;
   logic                 at_end;
   logic                 pair_match;
   logic                 sweep_drop;

   logic                         axis_load;
   logic                         axis_hit;
   logic signed [COORD_BITS-1:0] sel_a;
   logic signed [COORD_BITS-1:0] sel_b;
   logic [COORD_BITS-1:0]        sel_reach;

   // Route the current axis of the held item into the shared unit.
   always_comb begin
      case (axis_ff)
         2'd0: begin
            sel_a     = req_ff.center_a_x;
            sel_b     = req_ff.center_b_x;
            sel_reach = req_ff.reach_x;
         end
         2'd1: begin
            sel_a     = req_ff.center_a_y;
            sel_b     = req_ff.center_b_y;
            sel_reach = req_ff.reach_y;
         end
         default: begin
            sel_a     = req_ff.center_a_z;
            sel_b     = req_ff.center_b_z;
            sel_reach = req_ff.reach_z;
         end
      endcase
   end

   aabbct_axis_unit u_axis (
      .clock    (clock),
      .load     (axis_load),
      .center_a (sel_a),
      .center_b (sel_b),
      .reach    (sel_reach),
      .hit      (axis_hit)
   );

   // Table entry under the walk pointer.
   assign cur_idx    = idx_ff[SLOT_BITS-1:0];
   assign ent_first  = pair_first_ff[cur_idx];
   assign ent_second = pair_second_ff[cur_idx];
   assign ent_seen   = seen_ff[cur_idx];
   assign at_end     = (idx_ff >= count_ff);

   // A stored pair matches the test ids in either order.
   assign pair_match = ((ent_first == req_ff.id_a) && (ent_second == req_ff.id_b)) ||
                       ((ent_first == req_ff.id_b) && (ent_second == req_ff.id_a));

   // End of frame drops unseen pairs; remove drops pairs holding id_a.
   assign sweep_drop = (req_ff.func == FUNC_FRAME) ? !ent_seen :
                       ((ent_first == req_ff.id_a) || (ent_second == req_ff.id_a));

   assign busy = (state_ff != ST_IDLE);

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      axis_in       = axis_ff;
      idx_in        = idx_ff;
      wr_in         = wr_ff;
      count_in      = count_ff;
      seen_in       = seen_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      rsp_valid_in  = 1'b0;
      rsp_item_in   = rsp_item_ff;
      tab_we        = 1'b0;
      tab_waddr     = '0;
      tab_wfirst    = '0;
      tab_wsecond   = '0;
      axis_load     = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            // Take a new item and pick its path.
            if (start) begin
               req_in        = req_item;
               axis_in       = '0;
               idx_in        = '0;
               wr_in         = '0;
               pend_valid_in = 1'b0;
               case (req_item.func)
                  FUNC_TEST: begin
                     state_in = (req_item.id_a != req_item.id_b) ? ST_DIFF : ST_FINISH;
                  end
                  FUNC_FRAME, FUNC_REMOVE: begin
                     state_in = ST_SWEEP;
                  end
                  default: begin
                     state_in = ST_FINISH;
                  end
               endcase
            end
         end

         ST_DIFF: begin
            // Register the centre difference of the current axis.
            axis_load = 1'b1;
            state_in  = ST_CMP;
         end

         ST_CMP: begin
            // Drop out on the first axis that misses.
            if (!axis_hit) begin
               state_in = ST_FINISH;
            end else if (axis_ff == AXIS_LAST) begin
               state_in = ST_SEARCH;
            end else begin
               axis_in  = axis_ff + 2'd1;
               state_in = ST_DIFF;
            end
         end

         ST_SEARCH: begin
            if (at_end) begin
               pend_valid_in         = 1'b1;
               pend_in.first_id      = req_ff.id_a;
               pend_in.second_id     = req_ff.id_b;
               pend_in.last_of_run   = 1'b0;
               if (count_ff == CNT_BITS'(PAIR_SLOTS)) begin
                  pend_in.event_res = EV_DROPPED;
               end else begin
                  // Append the new pair, already seen this frame.
                  pend_in.event_res  = EV_ENTER;
                  tab_we             = 1'b1;
                  tab_waddr          = count_ff[SLOT_BITS-1:0];
                  tab_wfirst         = req_ff.id_a;
                  tab_wsecond        = req_ff.id_b;
                  seen_in[tab_waddr] = 1'b1;
                  count_in           = count_ff + 1'b1;
               end
               state_in = ST_FINISH;
            end else if (pair_match) begin
               seen_in[cur_idx]    = 1'b1;
               pend_valid_in       = 1'b1;
               pend_in.event_res   = EV_STAY;
               pend_in.first_id    = ent_first;
               pend_in.second_id   = ent_second;
               pend_in.last_of_run = 1'b0;
               state_in            = ST_FINISH;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end

         ST_SWEEP: begin
            if (at_end) begin
               // Clear marks past the compacted tail and shrink the table.
               for (int j = 0; j < PAIR_SLOTS; j++) begin
                  if (CNT_BITS'(j) >= wr_ff) begin
                     seen_in[j] = 1'b0;
                  end
               end
               count_in = wr_ff;
               state_in = ST_FINISH;
            end else begin
               if (sweep_drop) begin
                  // Release the held exit, hold this one until the next is known.
                  if (pend_valid_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_item_in  = pend_ff;
                  end
                  pend_valid_in       = 1'b1;
                  pend_in.event_res   = EV_EXIT;
                  pend_in.first_id    = ent_first;
                  pend_in.second_id   = ent_second;
                  pend_in.last_of_run = 1'b0;
               end else begin
                  // Move the kept pair down to the write pointer.
                  tab_we             = 1'b1;
                  tab_waddr          = wr_ff[SLOT_BITS-1:0];
                  tab_wfirst         = ent_first;
                  tab_wsecond        = ent_second;
                  seen_in[tab_waddr] = (req_ff.func == FUNC_FRAME) ? 1'b0 : ent_seen;
                  wr_in              = wr_ff + 1'b1;
               end
               idx_in = idx_ff + 1'b1;
            end
         end

         ST_FINISH: begin
            // Emit the held result, or none, as the last of the run.
            rsp_valid_in = 1'b1;
            if (pend_valid_ff) begin
               rsp_item_in = pend_ff;
            end else begin
               rsp_item_in.event_res = EV_NONE;
               rsp_item_in.first_id  = '0;
               rsp_item_in.second_id = '0;
            end
            rsp_item_in.last_of_run = 1'b1;
            pend_valid_in           = 1'b0;
            state_in                = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         seen_ff       <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         axis_ff       <= '0;
         idx_ff        <= '0;
         wr_ff         <= '0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         seen_ff       <= seen_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         axis_ff       <= axis_in;
         idx_ff        <= idx_in;
         wr_ff         <= wr_in;
      end
      req_ff      <= req_in;
      pend_ff     <= pend_in;
      rsp_item_ff <= rsp_item_in;
      if (tab_we) begin
         pair_first_ff[tab_waddr]  <= tab_wfirst;
         pair_second_ff[tab_waddr] <= tab_wsecond;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

`include "aabb_contact_pair_tracker_unit_assert.svh"

   `AABBCT_ASSERT_NOW(a_mid_run_busy, rsp_valid && !rsp_item.last_of_run, busy, "idle mid-run")
   `AABBCT_ASSERT_NOW(a_last_idle, rsp_valid && rsp_item.last_of_run, !busy, "busy at last")
   `AABBCT_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")
   `AABBCT_ASSERT_NOW(a_count_range, 1'b1, count_ff <= CNT_BITS'(PAIR_SLOTS), "pair count overflow")
   `AABBCT_ASSERT_NOW(a_seen_tail, !busy, (seen_ff >> count_ff) == '0, "seen mark past table end")

endmodule
